// ===== src/gpr_pkg.sv =====
// Shared register codes, constants, types and helpers of the GPIO port register block.
package gpr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PIN_W  = 16;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned KEY_POS = 16;

    localparam logic [DATA_W-1:0] MODE_RESET = 32'h4444_4444;

    localparam logic [IDX_W-1:0] REG_MODE_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MODE_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_INPUT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUTPUT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SET_RESET = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESET     = 3'd5;
    localparam logic [IDX_W-1:0] REG_LOCK      = 3'd6;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic [PIN_W-1:0] mask;
        logic             active;
    } t_lock_status;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [PIN_W-1:0]  pin_levels;
    } t_bus_req;

    // Widens eight per-pin bits into a mask that covers each pin's mode nibble.
    function automatic logic [DATA_W-1:0] nibble_mask(input logic [7:0] bits8);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[4*i +: 4] = {4{bits8[i]}};
        end
        return m;
    endfunction

endpackage

// ===== src/gpr_lock.sv =====
// Lock key sequencer: tracks the three-write key sequence and holds the lock bits.
module gpr_lock
    import gpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [KEY_POS:0]  i_wr_data,
    output t_lock_status      o_status
);

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_ONE  = 2'd1;
    localparam logic [1:0] STEP_TWO  = 2'd2;

    logic [1:0]       r_step;
    logic [PIN_W-1:0] r_mask;
    logic             r_active;
    logic [1:0]       n_step;
    logic [PIN_W-1:0] n_mask;
    logic             n_active;
    logic             w_key;
    logic             w_same;

    assign w_key  = i_wr_data[KEY_POS];
    assign w_same = (i_wr_data[PIN_W-1:0] == r_mask);

    always_comb begin
        n_step   = r_step;
        n_mask   = r_mask;
        n_active = r_active;
        if (i_wr_en && !r_active) begin
            n_mask = i_wr_data[PIN_W-1:0];
            n_step = w_key ? STEP_ONE : STEP_IDLE;
            unique case (r_step)
                STEP_ONE: begin
                    if (!w_key && w_same) begin
                        n_step = STEP_TWO;
                    end
                end
                STEP_TWO: begin
                    if (w_key && w_same) begin
                        n_active = 1'b1;
                        n_step   = STEP_IDLE;
                    end
                end
                default: begin
                    // Idle, and the unused code behaves as idle.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_IDLE;
            r_mask   <= '0;
            r_active <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_mask   <= n_mask;
            r_active <= n_active;
        end
    end

    assign o_status.mask   = r_mask;
    assign o_status.active = r_active;

endmodule

// ===== src/gpr_regfile.sv =====
// Mode and output data registers with the read multiplexer of the port.
module gpr_regfile
    import gpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_bus_req            i_req,
    input  t_lock_status        i_lock,
    output logic [DATA_W-1:0]   o_read_data,
    output logic [PIN_W-1:0]    o_out_next,
    output logic [2*DATA_W-1:0] o_modes_next
);

    logic [DATA_W-1:0] r_mode_low;
    logic [DATA_W-1:0] r_mode_high;
    logic [PIN_W-1:0]  r_out_data;
    logic [DATA_W-1:0] n_mode_low;
    logic [DATA_W-1:0] n_mode_high;
    logic [PIN_W-1:0]  n_out_data;
    logic [DATA_W-1:0] w_keep_low;
    logic [DATA_W-1:0] w_keep_high;
    logic [DATA_W-1:0] w_wd;

    assign w_wd = i_req.write_data;

    // Nibbles of locked pins are kept only once the lock has taken effect.
    assign w_keep_low  = i_lock.active ? nibble_mask(i_lock.mask[7:0])  : '0;
    assign w_keep_high = i_lock.active ? nibble_mask(i_lock.mask[15:8]) : '0;

    always_comb begin
        n_mode_low  = r_mode_low;
        n_mode_high = r_mode_high;
        n_out_data  = r_out_data;
        if (i_req.req_type == REQ_WRITE) begin
            unique case (i_req.reg_index)
                REG_MODE_LOW: begin
                    n_mode_low = (r_mode_low & w_keep_low) | (w_wd & ~w_keep_low);
                end
                REG_MODE_HIGH: begin
                    n_mode_high = (r_mode_high & w_keep_high) | (w_wd & ~w_keep_high);
                end
                REG_OUTPUT: begin
                    n_out_data = w_wd[PIN_W-1:0];
                end
                REG_SET_RESET: begin
                    // Set wins over reset where a pin has both.
                    n_out_data = (r_out_data & ~w_wd[DATA_W-1:PIN_W]) | w_wd[PIN_W-1:0];
                end
                REG_RESET: begin
                    n_out_data = r_out_data & ~w_wd[PIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_read_data = '0;
        if (i_req.req_type == REQ_READ) begin
            unique case (i_req.reg_index)
                REG_MODE_LOW:  o_read_data = r_mode_low;
                REG_MODE_HIGH: o_read_data = r_mode_high;
                REG_INPUT:     o_read_data = {{(DATA_W-PIN_W){1'b0}}, i_req.pin_levels};
                REG_OUTPUT:    o_read_data = {{(DATA_W-PIN_W){1'b0}}, r_out_data};
                REG_LOCK: begin
                    o_read_data = {{(DATA_W-PIN_W-1){1'b0}}, i_lock.active, i_lock.mask};
                end
                default:       o_read_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_low  <= MODE_RESET;
            r_mode_high <= MODE_RESET;
            r_out_data  <= '0;
        end else if (i_en) begin
            r_mode_low  <= n_mode_low;
            r_mode_high <= n_mode_high;
            r_out_data  <= n_out_data;
        end
    end

    assign o_out_next   = n_out_data;
    assign o_modes_next = {n_mode_high, n_mode_low};

endmodule

// ===== src/gpio_port_register_block_top.sv =====
// Top level of the GPIO port register block: input stage, result stage and assertions.
//
// Each input beat is one bus access (read or write of a port register) together
// with the sampled levels of the 16 pins. Each input beat yields exactly one
// result beat: the read data (zero for a write), the output data register and
// both mode words as they stand after the access.
// Both channels hand over a beat when valid is high and stall is low.
// A beat accepted into the input register moves into the result register as
// soon as the result stage is empty or the receiver is not stalling.
// Throughput: one beat per cycle while the receiver does not stall; the
// register update and read multiplexer sit in a single shallow stage
// between the two registers.
// When the receiver stalls, the result register holds its beat, the input
// register fills with one more beat, and only then does o_stall rise.
// A synchronous active-low reset empties both stages, sets both mode words to
// 0x44444444, clears the output data and clears the lock.
module gpio_port_register_block_top
    import gpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_req_type,
    input  logic [IDX_W-1:0]    i_reg_index,
    input  logic [DATA_W-1:0]   i_write_data,
    input  logic [PIN_W-1:0]    i_pin_levels,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DATA_W-1:0]   o_read_data,
    output logic [PIN_W-1:0]    o_output_levels,
    output logic [2*DATA_W-1:0] o_pin_modes
);

    logic                r_in_valid;
    t_bus_req            r_in_req;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_read_data;
    logic [PIN_W-1:0]    r_output_levels;
    logic [2*DATA_W-1:0] r_pin_modes;
    logic                n_in_valid;
    logic                n_out_valid;
    logic                w_out_ready;
    logic                w_process;
    logic                w_accept;
    logic                w_lock_wr;
    t_lock_status        w_lock;
    logic [DATA_W-1:0]   w_read_data;
    logic [PIN_W-1:0]    w_out_next;
    logic [2*DATA_W-1:0] w_modes_next;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_process   = r_in_valid && w_out_ready;
    assign o_stall     = r_in_valid && !w_out_ready;
    assign w_accept    = i_valid && !o_stall;

    assign w_lock_wr = w_process && (r_in_req.req_type == REQ_WRITE)
                       && (r_in_req.reg_index == REG_LOCK);

    gpr_lock u_lock (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_lock_wr),
        .i_wr_data (r_in_req.write_data[KEY_POS:0]),
        .o_status  (w_lock)
    );

    gpr_regfile u_regfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_process),
        .i_req        (r_in_req),
        .i_lock       (w_lock),
        .o_read_data  (w_read_data),
        .o_out_next   (w_out_next),
        .o_modes_next (w_modes_next)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_process) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_process) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_req.req_type   <= i_req_type;
            r_in_req.reg_index  <= i_reg_index;
            r_in_req.write_data <= i_write_data;
            r_in_req.pin_levels <= i_pin_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_read_data     <= w_read_data;
            r_output_levels <= w_out_next;
            r_pin_modes     <= w_modes_next;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_output_levels = r_output_levels;
    assign o_pin_modes     = r_pin_modes;

`ifndef ASSERT_OFF
    // The input side only backs up when both stages hold a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stall raised while a stage is empty");

    // Once the lock takes effect it stays until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lock.active |=> w_lock.active)
        else $error("lock released without reset");

    // A write beat always produces a zero read data word.
    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_process && (r_in_req.req_type == REQ_WRITE)) |=> (o_read_data == '0))
        else $error("write beat returned nonzero read data");

    // A processed beat always lands in the result stage.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> o_valid)
        else $error("processed beat missing from result stage");
`endif

endmodule

// ===== tb/sv/gpio_port_register_block_top_tb.sv =====
// Self-checking testbench for the GPIO port register block: directed rows and random bus traffic.
module gpio_port_register_block_top_tb;
    import gpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [2*DATA_W-1:0] RESET_MODES = {MODE_RESET, MODE_RESET};
    localparam int N_ROWS = 30;
    // The lock can only be undone by reset, so rows from here on are walked after the
    // unlocked random phase.
    localparam int LOCK_SPLIT = 21;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [1:0] {
        LOCK_IDLE   = 2'd0,
        LOCK_KEY_HI = 2'd1,
        LOCK_KEY_LO = 2'd2
    } t_lock_seq;

    typedef struct packed {
        logic [DATA_W-1:0]   rd;
        logic [PIN_W-1:0]    outl;
        logic [2*DATA_W-1:0] modes;
    } t_port_view;

    typedef struct packed {
        logic              gold;
        logic              rt;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wd;
        logic [PIN_W-1:0]  pins;
        t_port_view        view;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_req_type = REQ_READ;
    logic [IDX_W-1:0]    i_reg_index = REG_MODE_LOW;
    logic [DATA_W-1:0]   i_write_data = '0;
    logic [PIN_W-1:0]    i_pin_levels = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DATA_W-1:0]   o_read_data;
    logic [PIN_W-1:0]    o_output_levels;
    logic [2*DATA_W-1:0] o_pin_modes;

    // Travels with each beat so the monitor knows whether a typed-in result applies.
    t_stim_row beat_row = '0;

    t_stim_row  dir_rows [0:N_ROWS-1];
    t_port_view expected_views [$];
    int         err_count = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;

    // Port state as the bus sees it.
    logic [DATA_W-1:0] port_mode_lo = MODE_RESET;
    logic [DATA_W-1:0] port_mode_hi = MODE_RESET;
    logic [PIN_W-1:0]  port_out = '0;
    logic [PIN_W-1:0]  port_lock_mask = '0;
    logic              port_lock_on = 1'b0;
    t_lock_seq         port_lock_seq = LOCK_IDLE;

    gpio_port_register_block_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .i_pin_levels   (i_pin_levels),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_output_levels(o_output_levels),
        .o_pin_modes    (o_pin_modes)
    );

    always #1 i_clk = ~i_clk;

    // Nibbles of locked pins are kept across a mode word write.
    function automatic logic [DATA_W-1:0] locked_nibbles(input logic [7:0] lock8);
        logic [DATA_W-1:0] keep;
        keep = '0;
        if (port_lock_on) begin
            for (int p = 0; p < 8; p++) begin
                if (lock8[p]) begin
                    keep[4*p +: 4] = 4'hF;
                end
            end
        end
        return keep;
    endfunction

    function automatic t_port_view port_access(input logic wr, input logic [IDX_W-1:0] idx,
                                               input logic [DATA_W-1:0] w,
                                               input logic [PIN_W-1:0] pins);
        t_port_view v;
        logic [DATA_W-1:0] keep;
        logic key;
        v = '0;
        if (wr == REQ_READ) begin
            case (idx)
                REG_MODE_LOW:  v.rd = port_mode_lo;
                REG_MODE_HIGH: v.rd = port_mode_hi;
                REG_INPUT:     v.rd = {{(DATA_W-PIN_W){1'b0}}, pins};
                REG_OUTPUT:    v.rd = {{(DATA_W-PIN_W){1'b0}}, port_out};
                REG_LOCK:      v.rd = {{(DATA_W-KEY_POS-1){1'b0}}, port_lock_on, port_lock_mask};
                default:       v.rd = '0;
            endcase
        end else begin
            case (idx)
                REG_MODE_LOW: begin
                    keep = locked_nibbles(port_lock_mask[7:0]);
                    port_mode_lo = (port_mode_lo & keep) | (w & ~keep);
                end
                REG_MODE_HIGH: begin
                    keep = locked_nibbles(port_lock_mask[15:8]);
                    port_mode_hi = (port_mode_hi & keep) | (w & ~keep);
                end
                REG_OUTPUT:    port_out = w[PIN_W-1:0];
                REG_SET_RESET: port_out = (port_out & ~w[DATA_W-1:PIN_W]) | w[PIN_W-1:0];
                REG_RESET:     port_out = port_out & ~w[PIN_W-1:0];
                REG_LOCK: begin
                    if (!port_lock_on) begin
                        key = w[KEY_POS];
                        if (port_lock_seq == LOCK_KEY_HI && !key
                                && w[PIN_W-1:0] == port_lock_mask) begin
                            port_lock_seq = LOCK_KEY_LO;
                        end else if (port_lock_seq == LOCK_KEY_LO && key
                                && w[PIN_W-1:0] == port_lock_mask) begin
                            port_lock_on = 1'b1;
                            port_lock_seq = LOCK_IDLE;
                        end else if (key) begin
                            port_lock_seq = LOCK_KEY_HI;
                        end else begin
                            port_lock_seq = LOCK_IDLE;
                        end
                        port_lock_mask = w[PIN_W-1:0];
                    end
                end
                default: ;
            endcase
        end
        v.outl = port_out;
        v.modes = {port_mode_hi, port_mode_lo};
        return v;
    endfunction

    task automatic check_field(input string name, input logic [2*DATA_W-1:0] want,
                               input logic [2*DATA_W-1:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        end
    endtask

    // Result checking, expectation capture and the watchdog, all on sampled pre-edge values.
    always @(posedge i_clk) begin : monitor
        t_port_view got;
        t_port_view want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_read_data, o_output_levels, o_pin_modes};
                if (expected_views.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result beat: expected none, actual %h",
                                 $time, got);
                    end
                end else begin
                    want = expected_views.pop_front();
                    check_field("read_data", 64'(want.rd), 64'(got.rd));
                    check_field("output_levels", 64'(want.outl), 64'(got.outl));
                    check_field("pin_modes", want.modes, got.modes);
                end
            end
            if (i_valid && !o_stall) begin
                want = port_access(i_req_type, i_reg_index, i_write_data, i_pin_levels);
                if (beat_row.gold) begin
                    want = beat_row.view;
                end
                expected_views.push_back(want);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: segments of different stall patterns, and one long hold-off that
    // backs the block up into its input.
    initial begin : receiver
        int seg;
        int pattern;
        seg = 0;
        @(posedge i_clk);
        forever begin
            pattern = $urandom_range(0, 3);
            if (seg == 12) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else begin
                for (int k = 0; k < 64; k++) begin
                    case (pattern)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 3) == 0);
                        2: i_stall <= (k % 3 == 0);
                        default: i_stall <= ((k % 16) < 7);
                    endcase
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    // Offers one beat and returns at the edge that accepts it.
    task automatic send_beat(input t_stim_row r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        beat_row     <= r;
        i_req_type   <= r.rt;
        i_reg_index  <= r.idx;
        i_write_data <= r.wd;
        i_pin_levels <= r.pins;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    function automatic t_stim_row any_access();
        t_stim_row r;
        r = '0;
        r.rt = 1'($urandom_range(0, 1));
        r.idx = IDX_W'($urandom_range(0, 7));
        r.wd = $urandom;
        r.pins = PIN_W'($urandom);
        return r;
    endfunction

    function automatic t_stim_row lock_write(input logic key, input logic [PIN_W-1:0] bits);
        t_stim_row r;
        r = any_access();
        r.rt = REQ_WRITE;
        r.idx = REG_LOCK;
        r.wd[KEY_POS] = key;
        r.wd[PIN_W-1:0] = bits;
        return r;
    endfunction

    function automatic logic [PIN_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return PIN_W'($urandom);
        endcase
    endfunction

    task automatic send_noise(input int most, inout int sent);
        int n;
        n = $urandom_range(0, most);
        repeat (n) begin
            send_beat(any_access());
            sent++;
        end
    endtask

    // Before the lock closes: key sequences with random masks, each broken at some step,
    // mixed with random accesses.
    task automatic run_unlocked_phase(input int n);
        int sent;
        logic [PIN_W-1:0] m;
        logic [PIN_W-1:0] other;
        logic second_broken;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 5) begin
                m = pick_mask();
                other = m ^ PIN_W'($urandom_range(1, 16'hFFFF));
                send_beat(lock_write(1'b1, m));
                sent++;
                send_noise(2, sent);
                second_broken = ($urandom_range(0, 4) == 0);
                if (second_broken && $urandom_range(0, 1)) begin
                    send_beat(lock_write(1'b1, m));
                end else begin
                    send_beat(lock_write(1'b0, second_broken ? other : m));
                end
                sent++;
                send_noise(2, sent);
                if (second_broken) begin
                    send_beat(lock_write(1'b1, m));
                end else if ($urandom_range(0, 1)) begin
                    send_beat(lock_write(1'b0, m));
                end else begin
                    send_beat(lock_write(1'b1, other));
                end
                sent++;
                if ($urandom_range(0, 1)) begin
                    send_beat(lock_write(1'b0, '0));
                    sent++;
                end
            end else begin
                send_noise(8, sent);
            end
        end
    endtask

    initial begin : stimulus
        dir_rows = '{
            '{1'b1, REQ_READ,  REG_MODE_LOW,  32'h0, 16'h0, '{MODE_RESET, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_MODE_HIGH, 32'h0, 16'h0, '{MODE_RESET, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_INPUT,     32'h0, 16'hFFFF,
              '{32'h0000_FFFF, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_OUTPUT,    32'h0, 16'hFFFF, '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_SET_RESET, 32'hFFFF_FFFF, 16'h0, '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_RESET,     32'hFFFF_FFFF, 16'h0, '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_LOCK,      32'h0, 16'h0, '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_READ,  REG_UNUSED,    32'hFFFF_FFFF, 16'hFFFF,
              '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_WRITE, REG_INPUT,     32'hFFFF_FFFF, 16'h0, '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_WRITE, REG_UNUSED,    32'hFFFF_FFFF, 16'h0, '{32'h0, 16'h0, RESET_MODES}},
            '{1'b1, REQ_WRITE, REG_OUTPUT,    32'hFFFF_FFFF, 16'h0,
              '{32'h0, 16'hFFFF, RESET_MODES}},
            '{1'b1, REQ_WRITE, REG_RESET,     32'h0000_00FF, 16'h0,
              '{32'h0, 16'hFF00, RESET_MODES}},
            '{1'b1, REQ_WRITE, REG_SET_RESET, 32'hFFFF_0000, 16'h0, '{32'h0, 16'h0, RESET_MODES}},
            // Set wins over reset where a bit is given both ways.
            '{1'b1, REQ_WRITE, REG_SET_RESET, 32'hFFFF_00F0, 16'h0,
              '{32'h0, 16'h00F0, RESET_MODES}},
            '{1'b1, REQ_WRITE, REG_MODE_LOW,  32'h0, 16'h0,
              '{32'h0, 16'h00F0, {MODE_RESET, 32'h0}}},
            '{1'b1, REQ_WRITE, REG_MODE_HIGH, 32'hFFFF_FFFF, 16'h0,
              '{32'h0, 16'h00F0, {32'hFFFF_FFFF, 32'h0}}},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0001_1234, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0001_1234, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0000_1234, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0001_4321, 16'h0, '0},
            '{1'b0, REQ_READ,  REG_LOCK,      32'h0, 16'h5A5A, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'hFFFE_A5C3, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0001_A5C3, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0000_A5C3, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'hFFFF_A5C3, 16'h0, '0},
            '{1'b0, REQ_READ,  REG_LOCK,      32'h0, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_MODE_LOW,  32'h0, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_MODE_HIGH, 32'hFFFF_FFFF, 16'h0, '0},
            '{1'b0, REQ_WRITE, REG_LOCK,      32'h0000_0000, 16'h0, '0},
            '{1'b0, REQ_READ,  REG_LOCK,      32'h0, 16'h0, '0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < LOCK_SPLIT; r++) begin
            send_beat(dir_rows[r]);
        end
        run_unlocked_phase(900);
        for (int r = LOCK_SPLIT; r < N_ROWS; r++) begin
            send_beat(dir_rows[r]);
        end
        // Locked from here on: lock writes are ignored and mode writes keep locked nibbles.
        repeat (700) send_beat(any_access());
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_views.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
